[rtl/core/dftu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dftu_pkg;

    localparam int BYTE_W  = 8;
    localparam int SPEED_W = 16;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 6;
    localparam int CFG_A_W = 1;

    localparam logic [BYTE_W-1:0] OPEN_MARK  = 8'h28;
    localparam logic [BYTE_W-1:0] CLOSE_MARK = 8'h29;

    localparam logic [SPEED_W-1:0] MIN_SPEED_RST = 16'd1100;
    localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 16'd1900;

    typedef enum logic [CFG_A_W-1:0] {
        REG_MIN_SPEED = 1'b0,
        REG_MAX_SPEED = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_WAIT_OPEN,
        ST_PAYLOAD,
        ST_WAIT_CLOSE,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

    typedef struct packed {
        logic             in_ready;
        logic             cap_tool;
        logic             cap_lo;
        logic             wr_word;
        logic             rd_en;
        logic             load_out;
        logic             out_valid;
        logic             last;
        logic [IDX_W-1:0] motor_idx;
    } cmd_t;

    typedef struct packed {
        logic is_open;
        logic is_close;
    } status_t;

endpackage

`default_nettype wire

[rtl/core/dftu_byte_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface dftu_byte_if import dftu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/dftu_result_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface dftu_result_if import dftu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   thruster_index;
    logic [SPEED_W-1:0] thruster_speed;
    logic [BYTE_W-1:0]  tool_outputs;
    logic               last_of_frame;

    modport source (
        output valid, output thruster_index, output thruster_speed,
        output tool_outputs, output last_of_frame, input ready
    );
    modport sink (
        input valid, input thruster_index, input thruster_speed,
        input tool_outputs, input last_of_frame, output ready
    );
endinterface

`default_nettype wire

[rtl/core/dftu_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface dftu_cfg_if import dftu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CFG_A_W-1:0] addr;
    logic [SPEED_W-1:0] wdata;

    modport source (output valid, output addr, output wdata, input ready);
    modport sink (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

[rtl/core/delimited_frame_thruster_unpacker.sv]
// Delimited frame unpacker for thruster speeds and tool switches.
// rx (sink): one serial byte per word. A frame is '(' , one tool byte,
//   MOTORS little-endian 16-bit speeds, then ')'. Bytes outside a frame
//   other than '(' are dropped; a frame whose close byte is wrong is dropped.
// res (source): MOTORS words per good frame, index 0 first, speed clamped
//   to [min_speed, max_speed], tool bits masked to TOOLS, last_of_frame on
//   the final word.
// cfg (sink): addr 0 writes min_speed, addr 1 writes max_speed; always ready.
// Flow: after the close byte is accepted, each result in turn goes through
//   the speed RAM read, the clamp and the output register; the next result
//   starts only once the last one is taken by res.ready.
// rx accepts one byte per cycle while collecting; rx.ready is low while
//   results drain.
// Reset: parser waits for '(', min_speed = 1100, max_speed = 1900.
// Stall: a result stays on res, unchanged, until res.ready; nothing
//   advances meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module delimited_frame_thruster_unpacker import dftu_pkg::*; #(
    parameter int MOTORS = 6,
    parameter int TOOLS  = 8
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    dftu_cfg_if.sink       cfg,
    dftu_byte_if.sink      rx,
    dftu_result_if.source  res
);

    cmd_t    cmd;
    status_t status;

    assign cfg.ready = 1'b1;
    assign rx.ready  = cmd.in_ready;
    assign res.valid = cmd.out_valid;

    dftu_ctrl #(
        .MOTORS (MOTORS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx.valid),
        .out_ready (res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    dftu_dp #(
        .MOTORS (MOTORS),
        .TOOLS  (TOOLS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .rx_byte        (rx.rx_byte),
        .cfg_we         (cfg.valid),
        .cfg_addr       (cfg.addr),
        .cfg_wdata      (cfg.wdata),
        .thruster_index (res.thruster_index),
        .thruster_speed (res.thruster_speed),
        .tool_outputs   (res.tool_outputs),
        .last_of_frame  (res.last_of_frame)
    );

endmodule

`default_nettype wire

[rtl/core/dftu_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module dftu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 6,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/dftu_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module dftu_dp import dftu_pkg::*; #(
    parameter int MOTORS = 6,
    parameter int TOOLS  = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output status_t                 status,
    input  wire logic [BYTE_W-1:0]  rx_byte,
    input  wire logic               cfg_we,
    input  wire logic [CFG_A_W-1:0] cfg_addr,
    input  wire logic [SPEED_W-1:0] cfg_wdata,
    output logic [IDX_W-1:0]        thruster_index,
    output logic [SPEED_W-1:0]      thruster_speed,
    output logic [BYTE_W-1:0]       tool_outputs,
    output logic                    last_of_frame
);

    localparam int AW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam logic [BYTE_W-1:0] TOOL_MASK = BYTE_W'((1 << TOOLS) - 1);

    logic [SPEED_W-1:0] min_speed_reg;
    logic [SPEED_W-1:0] max_speed_reg;
    logic [BYTE_W-1:0]  tool_reg;
    logic [BYTE_W-1:0]  lo_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [SPEED_W-1:0] speed_next;
    logic [IDX_W-1:0]   idx_reg;
    logic               last_reg;
    logic [SPEED_W-1:0] rd_word;
    logic [SPEED_W-1:0] upper_cut;

    assign status.is_open  = (rx_byte == OPEN_MARK);
    assign status.is_close = (rx_byte == CLOSE_MARK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_speed_reg <= MIN_SPEED_RST;
            max_speed_reg <= MAX_SPEED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_MIN_SPEED: min_speed_reg <= cfg_wdata;
                REG_MAX_SPEED: max_speed_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    dftu_ram #(
        .WIDTH (SPEED_W),
        .DEPTH (MOTORS)
    ) u_speed_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_word),
        .wr_addr (cmd.motor_idx[AW-1:0]),
        .wr_data ({rx_byte, lo_reg}),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.motor_idx[AW-1:0]),
        .rd_data (rd_word)
    );

    // clamp down to max first, then raise to min
    always_comb
    begin
        upper_cut  = (rd_word > max_speed_reg) ? max_speed_reg : rd_word;
        speed_next = (upper_cut < min_speed_reg) ? min_speed_reg : upper_cut;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_tool)
        begin
            tool_reg <= rx_byte & TOOL_MASK;
        end
        if (cmd.cap_lo)
        begin
            lo_reg <= rx_byte;
        end
        if (cmd.load_out)
        begin
            speed_reg <= speed_next;
            idx_reg   <= cmd.motor_idx;
            last_reg  <= cmd.last;
        end
    end

    assign thruster_index = idx_reg;
    assign thruster_speed = speed_reg;
    assign tool_outputs   = tool_reg;
    assign last_of_frame  = last_reg;

endmodule

`default_nettype wire

[rtl/core/dftu_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module dftu_ctrl import dftu_pkg::*; #(
    parameter int MOTORS = 6
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    rx_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam logic [CNT_W-1:0] LAST_BYTE  = CNT_W'(2 * MOTORS);
    localparam logic [IDX_W-1:0] LAST_MOTOR = IDX_W'(MOTORS - 1);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [IDX_W-1:0] motor_reg;
    logic [IDX_W-1:0] motor_next;
    logic             rx_fire;

    assign rx_fire = rx_valid & cmd.in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT_OPEN;
            cnt_reg   <= '0;
            motor_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            motor_reg <= motor_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        motor_next = motor_reg;
        case (state_reg)
            ST_WAIT_OPEN:
            begin
                cnt_next   = '0;
                motor_next = '0;
                if (rx_fire && status.is_open)
                begin
                    state_next = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD:
            begin
                if (rx_fire)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg != '0 && !cnt_reg[0])
                    begin
                        motor_next = motor_reg + 1'b1;
                    end
                    if (cnt_reg == LAST_BYTE)
                    begin
                        state_next = ST_WAIT_CLOSE;
                    end
                end
            end
            ST_WAIT_CLOSE:
            begin
                if (rx_fire)
                begin
                    cnt_next   = '0;
                    motor_next = '0;
                    state_next = status.is_close ? ST_EMIT_RD : ST_WAIT_OPEN;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (out_ready)
                begin
                    if (motor_reg == LAST_MOTOR)
                    begin
                        state_next = ST_WAIT_OPEN;
                        motor_next = '0;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                        motor_next = motor_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_WAIT_OPEN;
                cnt_next   = '0;
                motor_next = '0;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.motor_idx = motor_reg;
        cmd.last      = (motor_reg == LAST_MOTOR);
        case (state_reg)
            ST_WAIT_OPEN:
            begin
                cmd.in_ready = 1'b1;
            end
            ST_PAYLOAD:
            begin
                cmd.in_ready = 1'b1;
                if (rx_valid)
                begin
                    cmd.cap_tool = (cnt_reg == '0);
                    cmd.cap_lo   = cnt_reg[0];
                    cmd.wr_word  = (cnt_reg != '0) && !cnt_reg[0];
                end
            end
            ST_WAIT_CLOSE:
            begin
                cmd.in_ready = 1'b1;
            end
            ST_EMIT_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_EMIT_LD:
            begin
                cmd.load_out = 1'b1;
            end
            ST_EMIT_WAIT:
            begin
                cmd.out_valid = 1'b1;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_valid |-> !cmd.in_ready)
        else $error("input taken while a result is pending");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_WAIT && !out_ready)
            |=> (state_reg == ST_EMIT_WAIT && $stable(motor_reg)))
        else $error("stalled result not held");

    a_motor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_RD || state_reg == ST_EMIT_LD
            || state_reg == ST_EMIT_WAIT) |-> (motor_reg <= LAST_MOTOR))
        else $error("thruster index beyond last motor");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAYLOAD) |-> (cnt_reg <= LAST_BYTE))
        else $error("payload count overrun");

    a_emit_after_close: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_EMIT_RD && motor_reg == '0)
            |-> $past(state_reg == ST_WAIT_CLOSE && rx_fire && status.is_close))
        else $error("frame emitted without close delimiter");
`endif

endmodule

`default_nettype wire

[test/tb_delimited_frame_thruster_unpacker.sv]
`timescale 1ns / 1ps

module tb_delimited_frame_thruster_unpacker;
    import dftu_pkg::*;

    localparam int MOTORS         = 6;
    localparam int TOOLS          = 8;
    localparam int PAYLOAD_LEN    = 1 + 2 * MOTORS;
    localparam int DRAIN_CYCLES   = 3 * MOTORS + 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 24;

    typedef enum logic [1:0] {
        HUNT_OPEN,
        GATHER,
        AWAIT_CLOSE
    } frame_phase_t;

    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic [SPEED_W-1:0] speed;
        logic [BYTE_W-1:0]  tools;
        logic               last;
    } thrust_word_t;

    logic clk;
    logic rst_n;

    dftu_cfg_if    cfg_if ();
    dftu_byte_if   rx_if ();
    dftu_result_if res_if ();

    delimited_frame_thruster_unpacker #(
        .MOTORS (MOTORS),
        .TOOLS  (TOOLS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .rx    (rx_if),
        .res   (res_if)
    );

    logic [SPEED_W-1:0] lo_bound = MIN_SPEED_RST;
    logic [SPEED_W-1:0] hi_bound = MAX_SPEED_RST;
    frame_phase_t       frame_phase = HUNT_OPEN;
    int                 gathered = 0;
    logic [BYTE_W-1:0]  payload [PAYLOAD_LEN];
    thrust_word_t       pending_words [$];
    thrust_word_t       want;

    logic [SPEED_W-1:0] speed_plan [MOTORS];

    int  mismatch_count = 0;
    int  stall_cycles = 0;
    int  hold_req = 0;
    int  frame_items = 0;
    bit  idle_off = 1'b0;
    bit  tx_calm = 1'b0;

    always #5 clk = ~clk;

    function automatic logic [SPEED_W-1:0] clamp_speed(input logic [SPEED_W-1:0] v);
        logic [SPEED_W-1:0] r;
        r = v;
        if (r > hi_bound)
            r = hi_bound;
        if (r < lo_bound)
            r = lo_bound;
        return r;
    endfunction

    function automatic void advance_parser(input logic [BYTE_W-1:0] b);
        thrust_word_t w;
        case (frame_phase)
            GATHER:
            begin
                payload[gathered] = b;
                gathered++;
                if (gathered >= PAYLOAD_LEN)
                    frame_phase = AWAIT_CLOSE;
            end
            AWAIT_CLOSE:
            begin
                frame_phase = HUNT_OPEN;
                gathered = 0;
                if (b == CLOSE_MARK)
                begin
                    for (int j = 0; j < MOTORS; j++)
                    begin
                        w.idx   = IDX_W'(j);
                        w.speed = clamp_speed({payload[2 + 2 * j], payload[1 + 2 * j]});
                        w.tools = payload[0] & (8'hFF >> (8 - TOOLS));
                        w.last  = (j == MOTORS - 1);
                        pending_words.push_back(w);
                    end
                end
            end
            default:
            begin
                gathered = 0;
                frame_phase = (b == OPEN_MARK) ? GATHER : HUNT_OPEN;
            end
        endcase
    endfunction

    function automatic logic [SPEED_W-1:0] pick_speed();
        logic [SPEED_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = SPEED_W'($urandom);
            1: v = lo_bound + SPEED_W'($urandom_range(0, 2)) - 16'd1;
            2: v = hi_bound + SPEED_W'($urandom_range(0, 2)) - 16'd1;
            3: v = '0;
            4: v = '1;
            default: v = SPEED_W'($urandom_range(lo_bound, hi_bound));
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // one word per call; valid stays high after acceptance
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (!idle_off && !tx_calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 11);
            @(negedge clk);
            rx_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        advance_parser(b);
    endtask

    task automatic release_rx();
        @(negedge clk);
        rx_if.valid <= 1'b0;
    endtask

    task automatic send_planned(input logic [BYTE_W-1:0] tools, input logic [BYTE_W-1:0] close_b);
        send_byte(OPEN_MARK);
        send_byte(tools);
        for (int j = 0; j < MOTORS; j++)
        begin
            send_byte(speed_plan[j][7:0]);
            send_byte(speed_plan[j][15:8]);
        end
        send_byte(close_b);
        frame_items += PAYLOAD_LEN + 2;
    endtask

    task automatic send_frame(input bit good_close);
        logic [BYTE_W-1:0] close_b;
        for (int j = 0; j < MOTORS; j++)
            speed_plan[j] = pick_speed();
        close_b = CLOSE_MARK;
        if (!good_close)
        begin
            do
                close_b = ($urandom_range(0, 3) == 0) ? OPEN_MARK : BYTE_W'($urandom);
            while (close_b == CLOSE_MARK);
        end
        send_planned(BYTE_W'($urandom), close_b);
    endtask

    task automatic settle();
        release_rx();
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [SPEED_W-1:0] v);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= r;
        cfg_if.wdata <= v;
        do @(posedge clk); while (!cfg_if.ready);
        if (r == REG_MIN_SPEED)
            lo_bound = v;
        else
            hi_bound = v;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_bounds(input logic [SPEED_W-1:0] lo, input logic [SPEED_W-1:0] hi);
        settle();
        write_reg(REG_MIN_SPEED, lo);
        write_reg(REG_MAX_SPEED, hi);
    endtask

    task automatic test_reset_bounds();
        send_byte(CLOSE_MARK);
        send_byte(8'hFF);
        send_byte(8'h00);
        speed_plan = '{16'h0000, 16'hFFFF, 16'h2928, 16'd1100, 16'd1900, 16'd1500};
        send_planned(8'hFF, CLOSE_MARK);
    endtask

    task automatic test_bad_close();
        speed_plan = '{16'd1500, 16'h0029, 16'h2800, 16'd1099, 16'd1901, 16'h8000};
        send_planned(8'h00, OPEN_MARK);
        send_byte(CLOSE_MARK);
    endtask

    task automatic test_bound_extremes();
        set_bounds(16'd2000, 16'd1000);
        send_frame(1'b1);
        set_bounds(16'h0000, 16'hFFFF);
        send_frame(1'b1);
        set_bounds(16'hFFFF, 16'hFFFF);
        send_frame(1'b1);
        set_bounds(16'h0000, 16'h0000);
        send_frame(1'b1);
        set_bounds(16'hFFFF, 16'h0000);
        send_frame(1'b1);
    endtask

    task automatic test_backpressure();
        set_bounds(MIN_SPEED_RST, MAX_SPEED_RST);
        hold_req = 400;
        repeat (3) send_frame(1'b1);
    endtask

    task automatic test_drain_pause();
        send_frame(1'b1);
        release_rx();
        while (pending_words.size() != 0)
            @(posedge clk);
        send_frame(1'b1);
    endtask

    task automatic test_random_traffic();
        int goal;
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            set_bounds(SPEED_W'($urandom), SPEED_W'($urandom));
            goal = frame_items + RANDOM_ITEMS / 4;
            while (frame_items < goal)
            begin
                tx_calm = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 9))
                    0: send_byte(BYTE_W'($urandom));
                    1: send_frame(1'b0);
                    default: send_frame(1'b1);
                endcase
            end
        end
        tx_calm = 1'b0;
    endtask

    task automatic test_steady_stream();
        set_bounds(16'd1100, 16'd1900);
        idle_off = 1'b1;
        repeat (2) send_frame(1'b1);
    endtask

    // receiver: random stalls, calm stretches, long hold on request
    initial
    begin
        int hold_len;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_len = hold_req;
                hold_req = 0;
                res_if.ready <= 1'b0;
                repeat (hold_len - 1) @(negedge clk);
            end
            else if (!idle_off && $urandom_range(0, 5) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge clk);
            end
            else if (!idle_off && $urandom_range(0, 40) == 0)
            begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(20, 60) - 1) @(negedge clk);
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word idx=%0d speed=%0d",
                    res_if.thruster_index, res_if.thruster_speed));
            end
            else
            begin
                want = pending_words.pop_front();
                if (res_if.thruster_index !== want.idx || res_if.thruster_speed !== want.speed ||
                    res_if.tool_outputs !== want.tools || res_if.last_of_frame !== want.last)
                begin
                    report_mismatch($sformatf(
                        "got idx=%0d speed=%0d tools=%02h last=%0b, want %0d %0d %02h %0b",
                        res_if.thruster_index, res_if.thruster_speed, res_if.tool_outputs,
                        res_if.last_of_frame, want.idx, want.speed, want.tools, want.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.addr   = REG_MIN_SPEED;
        cfg_if.wdata  = '0;
        res_if.ready  = 1'b0;
        for (int k = 0; k < PAYLOAD_LEN; k++)
            payload[k] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_bounds();
        test_bad_close();
        test_bound_extremes();
        test_backpressure();
        test_drain_pause();
        test_random_traffic();
        test_steady_stream();

        settle();
        if (pending_words.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", pending_words.size()));
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
